/* hdl/wmas_pkg.sv */
// shared widths, reset values and the per-device entry layout
package wmas_pkg;

    localparam int DEV_W  = 3;
    localparam int ERR_W  = 64;
    localparam int DLY_W  = 32;
    localparam int SUM_W  = 64;
    localparam int CNT_W  = 32;
    localparam int TIME_W = 32;
    localparam int WIN_W  = 16;

    localparam int DEVICES_DEFAULT = 8;
    localparam logic [WIN_W-1:0] WINDOW_MS_RESET = 16'd1000;

    typedef struct packed {
        logic [ERR_W-1:0]  base;
        logic [TIME_W-1:0] last_pub;
        logic [CNT_W-1:0]  count;
        logic [SUM_W-1:0]  err_sum;
        logic [ERR_W-1:0]  err_low;
        logic [ERR_W-1:0]  err_high;
        logic [SUM_W-1:0]  dly_sum;
        logic [DLY_W-1:0]  dly_low;
        logic [DLY_W-1:0]  dly_high;
    } entry_t;

endpackage

/* hdl/wmas_div.sv */
// shared-control restoring divider: two 64-bit sums by one 32-bit sample count
module wmas_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wmas_pkg::SUM_W-1:0]    num_err,
    input  logic [wmas_pkg::SUM_W-1:0]    num_dly,
    input  logic [wmas_pkg::CNT_W-1:0]    den,
    output logic                          done,
    output logic [wmas_pkg::SUM_W-1:0]    quo_err,
    output logic [wmas_pkg::SUM_W-1:0]    quo_dly
);

    localparam int SW = wmas_pkg::SUM_W;
    localparam int CW = wmas_pkg::CNT_W;
    localparam int STEP_W = $clog2(SW);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SW - 1);

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SW-1:0]     err_q_reg;
    logic [SW-1:0]     dly_q_reg;
    logic [CW-1:0]     err_r_reg;
    logic [CW-1:0]     dly_r_reg;
    logic [CW-1:0]     den_reg;

    logic [CW:0]   err_trial;
    logic [CW:0]   dly_trial;
    logic [CW:0]   err_diff;
    logic [CW:0]   dly_diff;
    logic          err_ge;
    logic          dly_ge;
    logic [CW-1:0] err_r_next;
    logic [CW-1:0] dly_r_next;

    // one quotient bit per cycle; the dividend register fills with quotient bits
    always_comb
    begin
        err_trial  = {err_r_reg, err_q_reg[SW-1]};
        dly_trial  = {dly_r_reg, dly_q_reg[SW-1]};
        err_diff   = err_trial - {1'b0, den_reg};
        dly_diff   = dly_trial - {1'b0, den_reg};
        err_ge     = err_trial >= {1'b0, den_reg};
        dly_ge     = dly_trial >= {1'b0, den_reg};
        err_r_next = err_ge ? err_diff[CW-1:0] : err_trial[CW-1:0];
        dly_r_next = dly_ge ? dly_diff[CW-1:0] : dly_trial[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            err_q_reg <= num_err;
            dly_q_reg <= num_dly;
            err_r_reg <= '0;
            dly_r_reg <= '0;
            den_reg   <= den;
        end
        else if (run_reg)
        begin
            err_q_reg <= {err_q_reg[SW-2:0], err_ge};
            dly_q_reg <= {dly_q_reg[SW-2:0], dly_ge};
            err_r_reg <= err_r_next;
            dly_r_reg <= dly_r_next;
        end
    end

    assign done    = done_reg;
    assign quo_err = err_q_reg;
    assign quo_dly = dly_q_reg;

endmodule

/* hdl/windowed_min_avg_max_stats_top.sv */
// per-device windowed min / average / max statistics engine
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------------
//  in       | in_valid / in_ready   | device, error_count, lat_sample, now_ms
//  out      | out_valid / out_ready | device_out, incr_min/avg/max, lat_min/avg/max
//  cfg      | cfg_valid / cfg_ready | cfg_data (window_ms)
//
// a request that does not publish passes through entry read, then update and write-back
// a publishing request goes on through S_DIV, while the bit-serial divider runs, and then
// through S_FIN, which loads the output
// an out-of-range device is dropped in its accept cycle
// reset clears per-device valid flags at once; an entry not yet written reads as zero
// a finished result waits in the output register; a publishing request stalls further
// only while that register is still full
module windowed_min_avg_max_stats_top #(
    parameter int DEVICES = wmas_pkg::DEVICES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [wmas_pkg::DEV_W-1:0]   device,
    input  logic [wmas_pkg::ERR_W-1:0]   error_count,
    input  logic [wmas_pkg::DLY_W-1:0]   lat_sample,
    input  logic [wmas_pkg::TIME_W-1:0]  now_ms,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [wmas_pkg::DEV_W-1:0]   device_out,
    output logic [wmas_pkg::ERR_W-1:0]   incr_min,
    output logic [wmas_pkg::ERR_W-1:0]   incr_avg,
    output logic [wmas_pkg::ERR_W-1:0]   incr_max,
    output logic [wmas_pkg::DLY_W-1:0]   lat_min,
    output logic [wmas_pkg::DLY_W-1:0]   lat_avg,
    output logic [wmas_pkg::DLY_W-1:0]   lat_max,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [wmas_pkg::WIN_W-1:0]   cfg_data
);

    localparam int DEV_AW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int DEV_CW = ((DEV_AW > wmas_pkg::DEV_W) ? DEV_AW : wmas_pkg::DEV_W) + 1;
    localparam int SW = wmas_pkg::SUM_W;
    localparam int DW = wmas_pkg::DLY_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [wmas_pkg::WIN_W-1:0] window_reg;

    wmas_pkg::entry_t entry_mem [DEVICES];
    wmas_pkg::entry_t rd_data_reg;
    logic [DEVICES-1:0] valid_reg;
    logic               rd_valid_reg;

    logic [wmas_pkg::DEV_W-1:0]  dev_reg;
    logic [wmas_pkg::ERR_W-1:0]  err_in_reg;
    logic [wmas_pkg::DLY_W-1:0]  dly_in_reg;
    logic [wmas_pkg::TIME_W-1:0] now_reg;

    logic [wmas_pkg::ERR_W-1:0] st_err_low_reg;
    logic [wmas_pkg::ERR_W-1:0] st_err_high_reg;
    logic [DW-1:0]              st_dly_low_reg;
    logic [DW-1:0]              st_dly_high_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [wmas_pkg::DEV_W-1:0] out_dev_reg;
    logic [wmas_pkg::ERR_W-1:0] out_err_min_reg;
    logic [wmas_pkg::ERR_W-1:0] out_err_avg_reg;
    logic [wmas_pkg::ERR_W-1:0] out_err_max_reg;
    logic [DW-1:0]              out_dly_min_reg;
    logic [DW-1:0]              out_dly_avg_reg;
    logic [DW-1:0]              out_dly_max_reg;

    logic [DEV_CW-1:0] in_dev_ext;
    logic [DEV_CW-1:0] cur_dev_ext;
    logic              in_range;
    logic              accept;
    logic [DEV_AW-1:0] rd_addr;
    logic [DEV_AW-1:0] wr_addr;

    wmas_pkg::entry_t cur;
    wmas_pkg::entry_t upd;
    wmas_pkg::entry_t wr_data;
    logic [wmas_pkg::ERR_W-1:0]  inc;
    logic [wmas_pkg::TIME_W-1:0] elapsed;
    logic                        seed;
    logic                        publish;
    logic                        mem_we;
    logic                        div_start;
    logic                        div_done;
    logic [SW-1:0]               quo_err;
    logic [SW-1:0]               quo_dly;
    logic                        slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    assign in_dev_ext  = DEV_CW'(device);
    assign cur_dev_ext = DEV_CW'(dev_reg);
    assign in_range    = in_dev_ext < DEV_CW'(DEVICES);
    assign rd_addr     = in_dev_ext[DEV_AW-1:0];
    assign wr_addr     = cur_dev_ext[DEV_AW-1:0];
    assign slot_free   = !out_valid_reg || out_ready;

    // read-modify-write of one device entry
    always_comb
    begin
        cur  = rd_valid_reg ? rd_data_reg : '0;
        inc  = err_in_reg - cur.base;
        seed = (cur.count == '0);
        upd  = cur;
        if (seed)
        begin
            upd.count    = wmas_pkg::CNT_W'(1);
            upd.err_sum  = inc;
            upd.err_low  = inc;
            upd.err_high = inc;
            upd.dly_sum  = SW'(dly_in_reg);
            upd.dly_low  = dly_in_reg;
            upd.dly_high = dly_in_reg;
        end
        else
        begin
            upd.count   = cur.count + 1'b1;
            upd.err_sum = cur.err_sum + inc;
            upd.dly_sum = cur.dly_sum + SW'(dly_in_reg);
            if (cur.err_low > inc)
                upd.err_low = inc;
            if (cur.err_high < inc)
                upd.err_high = inc;
            if (cur.dly_low > dly_in_reg)
                upd.dly_low = dly_in_reg;
            if (cur.dly_high < dly_in_reg)
                upd.dly_high = dly_in_reg;
        end
        elapsed = now_reg - cur.last_pub;
        // a count that wraps to zero starts a fresh window without publishing
        publish = (upd.count != '0) &&
                  (elapsed >= wmas_pkg::TIME_W'(window_reg));

        wr_data = upd;
        if (publish)
        begin
            wr_data          = '0;
            wr_data.base     = err_in_reg;
            wr_data.last_pub = now_reg;
        end
        mem_we    = (state_reg == S_CALC);
        div_start = (state_reg == S_CALC) && publish;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_range)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                state_next = publish ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == S_FIN && slot_free)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= wmas_pkg::WINDOW_MS_RESET;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                window_reg <= cfg_data;
            if (accept && in_range)
                rd_valid_reg <= valid_reg[rd_addr];
            if (mem_we)
                valid_reg[wr_addr] <= 1'b1;
        end
    end

    // entry store: one read port at accept, one write port in the update cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[wr_addr] <= wr_data;
        if (accept && in_range)
            rd_data_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dev_reg    <= device;
            err_in_reg <= error_count;
            dly_in_reg <= lat_sample;
            now_reg    <= now_ms;
        end
        if (div_start)
        begin
            st_err_low_reg  <= upd.err_low;
            st_err_high_reg <= upd.err_high;
            st_dly_low_reg  <= upd.dly_low;
            st_dly_high_reg <= upd.dly_high;
        end
        if (state_reg == S_FIN && slot_free)
        begin
            out_dev_reg     <= dev_reg;
            out_err_min_reg <= st_err_low_reg;
            out_err_avg_reg <= quo_err;
            out_err_max_reg <= st_err_high_reg;
            out_dly_min_reg <= st_dly_low_reg;
            out_dly_avg_reg <= quo_dly[DW-1:0];
            out_dly_max_reg <= st_dly_high_reg;
        end
    end

    wmas_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_err (upd.err_sum),
        .num_dly (upd.dly_sum),
        .den     (upd.count),
        .done    (div_done),
        .quo_err (quo_err),
        .quo_dly (quo_dly)
    );

    assign out_valid  = out_valid_reg;
    assign device_out = out_dev_reg;
    assign incr_min   = out_err_min_reg;
    assign incr_avg   = out_err_avg_reg;
    assign incr_max   = out_err_max_reg;
    assign lat_min    = out_dly_min_reg;
    assign lat_avg    = out_dly_avg_reg;
    assign lat_max    = out_dly_max_reg;

    a_write_only_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == S_CALC)
        else $error("entry write outside update cycle");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result appeared without finished division");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished while not awaited");

    a_drop_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_range) |=> state_reg == S_IDLE)
        else $error("out-of-range device was processed");

    a_delay_avg_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (lat_min <= lat_avg) && (lat_avg <= lat_max))
        else $error("delay average outside min/max");

endmodule

/* tb/tb_top.sv */
// testbench for the windowed min / average / max statistics engine
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEVICES      = wmas_pkg::DEVICES_DEFAULT;
    localparam int          DEV_W        = wmas_pkg::DEV_W;
    localparam int          ERR_W        = wmas_pkg::ERR_W;
    localparam int          DLY_W        = wmas_pkg::DLY_W;
    localparam int          TIME_W       = wmas_pkg::TIME_W;
    localparam int          WIN_W        = wmas_pkg::WIN_W;
    localparam int          SUM_W        = wmas_pkg::SUM_W;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned TAIL_CYCLES  = 80;
    localparam int unsigned SETTLE_LIMIT = 20000;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_PUBLISH} row_kind_t;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [ERR_W-1:0] err_min;
        logic [ERR_W-1:0] err_avg;
        logic [ERR_W-1:0] err_max;
        logic [DLY_W-1:0] dly_min;
        logic [DLY_W-1:0] dly_avg;
        logic [DLY_W-1:0] dly_max;
    } window_stats_t;

    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [ERR_W-1:0]  errs;
        logic [DLY_W-1:0]  dly;
        logic [TIME_W-1:0] now;
        row_kind_t         kind;
        window_stats_t     want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [DEV_W-1:0]  device;
    logic [ERR_W-1:0]  error_count;
    logic [DLY_W-1:0]  lat_sample;
    logic [TIME_W-1:0] now_ms;
    logic out_valid;
    logic out_ready;
    logic [DEV_W-1:0] device_out;
    logic [ERR_W-1:0] incr_min;
    logic [ERR_W-1:0] incr_avg;
    logic [ERR_W-1:0] incr_max;
    logic [DLY_W-1:0] lat_min;
    logic [DLY_W-1:0] lat_avg;
    logic [DLY_W-1:0] lat_max;
    logic cfg_valid;
    logic cfg_ready;
    logic [WIN_W-1:0] cfg_data;

    // predictor state: one entry per device plus the window register
    wmas_pkg::entry_t dev_state [DEVICES];
    logic [WIN_W-1:0] window_cfg;

    window_stats_t pending_windows [$];
    stim_row_t     stim_rows [$];
    logic [ERR_W-1:0]  err_ctr [DEVICES];
    logic [TIME_W-1:0] now_clk;
    int unsigned mismatches;
    bit send_quiet;
    bit recv_quiet;
    bit hold_armed;

    windowed_min_avg_max_stats_top #(
        .DEVICES(DEVICES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .device(device),
        .error_count(error_count),
        .lat_sample(lat_sample),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .device_out(device_out),
        .incr_min(incr_min),
        .incr_avg(incr_avg),
        .incr_max(incr_max),
        .lat_min(lat_min),
        .lat_avg(lat_avg),
        .lat_max(lat_max),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // folds one sample into the device entry; returns 1 when the window closes
    function automatic bit fold_sample(input logic [DEV_W-1:0] dev,
                                       input logic [ERR_W-1:0] errs,
                                       input logic [DLY_W-1:0] dly,
                                       input logic [TIME_W-1:0] now,
                                       output window_stats_t res);
        wmas_pkg::entry_t  e;
        logic [ERR_W-1:0]  inc;
        logic [TIME_W-1:0] elapsed;
        e = dev_state[dev];
        inc = errs - e.base;
        res = '0;
        fold_sample = 1'b0;
        if (e.count == '0)
        begin
            e.count    = 1;
            e.err_sum  = inc;
            e.err_low  = inc;
            e.err_high = inc;
            e.dly_sum  = SUM_W'(dly);
            e.dly_low  = dly;
            e.dly_high = dly;
        end
        else
        begin
            e.err_sum = e.err_sum + inc;
            e.dly_sum = e.dly_sum + SUM_W'(dly);
            e.count   = e.count + 1'b1;
            if (e.err_low > inc)
                e.err_low = inc;
            if (e.err_high < inc)
                e.err_high = inc;
            if (e.dly_low > dly)
                e.dly_low = dly;
            if (e.dly_high < dly)
                e.dly_high = dly;
        end
        elapsed = now - e.last_pub;
        // a count that wrapped to zero never publishes
        if (e.count != '0 && elapsed >= TIME_W'(window_cfg))
        begin
            res.dev     = dev;
            res.err_min = e.err_low;
            res.err_avg = e.err_sum / SUM_W'(e.count);
            res.err_max = e.err_high;
            res.dly_min = e.dly_low;
            res.dly_avg = DLY_W'(e.dly_sum / SUM_W'(e.count));
            res.dly_max = e.dly_high;
            e = '0;
            e.last_pub = now;
            e.base = errs;
            fold_sample = 1'b1;
        end
        dev_state[dev] = e;
    endfunction

    task automatic send_req(input logic [DEV_W-1:0] dev, input logic [ERR_W-1:0] errs,
                            input logic [DLY_W-1:0] dly, input logic [TIME_W-1:0] now,
                            input row_kind_t kind, input window_stats_t typed);
        int unsigned   gap;
        window_stats_t res;
        bit            published;
        if ($urandom_range(0, 31) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        device      <= dev;
        error_count <= errs;
        lat_sample  <= dly;
        now_ms      <= now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        published = fold_sample(dev, errs, dly, now, res);
        if (kind == ROW_PUBLISH)
            pending_windows.push_back(typed);
        else if (kind == ROW_PREDICT && published)
            pending_windows.push_back(res);
    endtask

    task automatic add_row(input logic [DEV_W-1:0] dev, input logic [ERR_W-1:0] errs,
                           input logic [DLY_W-1:0] dly, input logic [TIME_W-1:0] now,
                           input row_kind_t kind,
                           input logic [ERR_W-1:0] emin, input logic [ERR_W-1:0] eavg,
                           input logic [ERR_W-1:0] emax, input logic [DLY_W-1:0] dmin,
                           input logic [DLY_W-1:0] davg, input logic [DLY_W-1:0] dmax);
        stim_row_t r;
        r.dev  = dev;
        r.errs = errs;
        r.dly  = dly;
        r.now  = now;
        r.kind = kind;
        r.want.dev     = dev;
        r.want.err_min = emin;
        r.want.err_avg = eavg;
        r.want.err_max = emax;
        r.want.dly_min = dmin;
        r.want.dly_avg = davg;
        r.want.dly_max = dmax;
        stim_rows.push_back(r);
    endtask

    // drop the input, wait for every pending window, then let the block go quiet
    task automatic settle();
        int unsigned waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_windows.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_windows.size() != 0)
        begin
            report($sformatf("%0d windows never published", pending_windows.size()));
            pending_windows.delete();
        end
    endtask

    task automatic write_window(input logic [WIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        window_cfg = val;
    endtask

    // mostly rising per-device counters and a shared rising timestamp, with some raw noise mixed in
    task automatic random_phase(input int n, input int unsigned step_max);
        logic [DEV_W-1:0] dev;
        logic [DLY_W-1:0] dly;
        repeat (n)
        begin
            dev = DEV_W'($urandom_range(0, DEVICES - 1));
            if ($urandom_range(0, 7) == 0)
            begin
                send_req(dev, {$urandom, $urandom}, $urandom, $urandom, ROW_PREDICT, '0);
            end
            else
            begin
                now_clk = now_clk + $urandom_range(0, step_max);
                if ($urandom_range(0, 15) == 0)
                    err_ctr[dev] = err_ctr[dev] + {$urandom, $urandom};
                else
                    err_ctr[dev] = err_ctr[dev] + ERR_W'($urandom_range(0, 1000));
                dly = ($urandom_range(0, 3) == 0) ? $urandom : DLY_W'($urandom_range(0, 5000));
                send_req(dev, err_ctr[dev], dly, now_clk, ROW_PREDICT, '0);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [WIN_W-1:0] win;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        device      = '0;
        error_count = '0;
        lat_sample  = '0;
        now_ms      = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        mismatches  = 0;
        send_quiet  = 1'b0;
        recv_quiet  = 1'b0;
        hold_armed  = 1'b0;
        window_cfg  = wmas_pkg::WINDOW_MS_RESET;
        foreach (dev_state[i])
            dev_state[i] = '0;
        foreach (err_ctr[i])
            err_ctr[i] = {$urandom, $urandom};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window at its reset value of 1000 ms, every entry zero
        add_row(0, 5, 100, 999, ROW_QUIET, 0, 0, 0, 0, 0, 0);
        add_row(0, 9, 300, 1000, ROW_PUBLISH, 5, 7, 9, 100, 200, 300);
        add_row(7, '1, '1, '1, ROW_PUBLISH, '1, '1, '1, '1, '1, '1);
        // error count and timestamp both wrap past the new base
        add_row(7, 0, 0, 999, ROW_PUBLISH, 1, 1, 1, 0, 0, 0);
        add_row(1, 0, 0, 0, ROW_QUIET, 0, 0, 0, 0, 0, 0);
        add_row(1, 64'h8000_0000_0000_0000, 32'h8000_0000, 500, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        add_row(1, '1, '1, 1500, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        // error sum wraps
        add_row(2, '1, 7, 10, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        add_row(2, '1, 9, 20, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        add_row(2, 3, 0, 1020, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        add_row(3, 123456789, 42, 5000, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        add_row(4, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, ROW_PREDICT,
                0, 0, 0, 0, 0, 0);
        add_row(5, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, ROW_PREDICT,
                0, 0, 0, 0, 0, 0);
        add_row(6, 1, 1, 1000, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        add_row(6, 2, 2, 1999, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        add_row(6, 3, 3, 2000, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        add_row(6, 10, 50, 2500, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        add_row(6, 4, 60, 2999, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        add_row(6, 20, 5, 3000, ROW_PREDICT, 0, 0, 0, 0, 0, 0);
        foreach (stim_rows[i])
            send_req(stim_rows[i].dev, stim_rows[i].errs, stim_rows[i].dly,
                     stim_rows[i].now, stim_rows[i].kind, stim_rows[i].want);
        settle();

        // zero window: every request publishes, and the output side holds off once
        write_window('0);
        hold_armed = 1'b1;
        now_clk = $urandom;
        random_phase(250, 100);
        settle();

        // widest window, timestamps wrap partway through
        write_window('1);
        now_clk = 32'hFFFF_0000;
        random_phase(250, 4096);
        settle();

        win = WIN_W'($urandom_range(16, 4000));
        write_window(win);
        now_clk = $urandom;
        random_phase(300, win / 16 + 1);
        settle();

        write_window(WIN_W'(200));
        now_clk = $urandom;
        random_phase(300, 13);
        settle();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned gap;
        out_ready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                recv_quiet = !recv_quiet;
            gap = recv_quiet ? 0 : $urandom_range(0, 9);
            // one long hold so the output register fills and the input backs up
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        window_stats_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_windows.size() == 0)
            begin
                report($sformatf("unexpected window for device %0d", device_out));
            end
            else
            begin
                want = pending_windows.pop_front();
                if (device_out !== want.dev)
                    report($sformatf("device_out %0d, want %0d", device_out, want.dev));
                if (incr_min !== want.err_min)
                    report($sformatf("incr_min %h, want %h", incr_min, want.err_min));
                if (incr_avg !== want.err_avg)
                    report($sformatf("incr_avg %h, want %h", incr_avg, want.err_avg));
                if (incr_max !== want.err_max)
                    report($sformatf("incr_max %h, want %h", incr_max, want.err_max));
                if (lat_min !== want.dly_min)
                    report($sformatf("lat_min %h, want %h", lat_min, want.dly_min));
                if (lat_avg !== want.dly_avg)
                    report($sformatf("lat_avg %h, want %h", lat_avg, want.dly_avg));
                if (lat_max !== want.dly_max)
                    report($sformatf("lat_max %h, want %h", lat_max, want.dly_max));
            end
        end
    end

    initial
    begin : watchdog
        #12_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
hdl/wmas_pkg.sv
hdl/wmas_div.sv
hdl/windowed_min_avg_max_stats_top.sv
tb/tb_top.sv
